/* sv/csl_pkg.sv */
`timescale 1ns / 1ps
package csl_pkg;
	localparam int POSITION_BITS_DEF = 16;
	localparam int NUMBER_BITS_DEF = 64;
	localparam logic [7:0] ESC_VALUE = 8'd27;
	localparam int RADIX = 10;

	typedef enum logic [2:0] {
		K_IDENT = 3'd0, K_KEYWORD = 3'd1, K_NUMBER = 3'd2, K_SBYTE = 3'd3,
		K_SEND = 3'd4, K_PUNCT = 3'd5, K_EOF = 3'd6, K_ERROR = 3'd7
	} kind_t;

	typedef enum logic [1:0] {
		E_INVALID = 2'd0, E_UNCLOSED = 2'd1, E_BADHEX = 2'd2
	} err_t;

	typedef enum logic [9:0] {
		M_IDLE      = 10'b0000000001,
		M_IDENT     = 10'b0000000010,
		M_NUMBER    = 10'b0000000100,
		M_PUNCT     = 10'b0000001000,
		M_STRING    = 10'b0000010000,
		M_ESC       = 10'b0000100000,
		M_OCTAL     = 10'b0001000000,
		M_HEX_FIRST = 10'b0010000000,
		M_HEX       = 10'b0100000000,
		M_ERROR     = 10'b1000000000
	} mode_t;

	// Decoded byte classes, computed in the front and queued.
	typedef struct packed {
		logic       eot;
		logic [7:0] b;
		logic       space;
		logic       digit;
		logic       lead;
		logic       punct;
		logic       cmp;
		logic       oct;
		logic       hex_ok;
		logic [3:0] hexv;
	} cls_t;

	function automatic logic [7:0] letter_escape(input logic [7:0] b);
		logic [7:0] r;
		case (b)
			8'h61: r = 8'd7;
			8'h62: r = 8'd8;
			8'h74: r = 8'd9;
			8'h6e: r = 8'd10;
			8'h76: r = 8'd11;
			8'h66: r = 8'd12;
			8'h72: r = 8'd13;
			8'h65: r = ESC_VALUE;
			default: r = b;
		endcase
		return r;
	endfunction

	// Keyword lookup by length and first 8 bytes; returns valid and index.
	function automatic logic [4:0] kw_match(input logic [3:0] len, input logic [63:0] p);
		logic [4:0] r;
		r = 5'd0;
		case (len)
			4'd2: begin
				if (p[15:0] == 16'h6669) r = {1'b1, 4'd1};
				else if (p[15:0] == 16'h6f64) r = {1'b1, 4'd5};
			end
			4'd3: begin
				if (p[23:0] == 24'h726f66) r = {1'b1, 4'd3};
				else if (p[23:0] == 24'h746e69) r = {1'b1, 4'd6};
			end
			4'd4: begin
				if (p[31:0] == 32'h65736c65) r = {1'b1, 4'd2};
				else if (p[31:0] == 32'h72616863) r = {1'b1, 4'd8};
			end
			4'd5: begin
				if (p[39:0] == 40'h656c696877) r = {1'b1, 4'd4};
			end
			4'd6: begin
				if (p[47:0] == 48'h6e7275746572) r = {1'b1, 4'd0};
				else if (p[47:0] == 48'h666f657a6973) r = {1'b1, 4'd7};
			end
			default: r = 5'd0;
		endcase
		return r;
	endfunction
endpackage

/* sv/csl_front.sv */
`timescale 1ns / 1ps
module csl_front import csl_pkg::*; #(
	parameter int QDEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] text_byte,
	input  logic       end_of_text,
	output logic       q_valid,
	input  logic       q_ready,
	output cls_t       q_data
);
	localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	cls_t c;
	cls_t mem_q [QDEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;
	logic wr, rd;

	always_comb begin
		c.eot = end_of_text;
		c.b = text_byte;
		c.space = (text_byte == 8'd32) || (text_byte >= 8'd9 && text_byte <= 8'd13);
		c.digit = text_byte >= 8'h30 && text_byte <= 8'h39;
		c.lead = (text_byte >= 8'h61 && text_byte <= 8'h7a) ||
			(text_byte >= 8'h41 && text_byte <= 8'h5a) || text_byte == 8'h5f;
		c.punct = (text_byte >= 8'd33 && text_byte <= 8'd47) ||
			(text_byte >= 8'd58 && text_byte <= 8'd64) ||
			(text_byte >= 8'd91 && text_byte <= 8'd96) ||
			(text_byte >= 8'd123 && text_byte <= 8'd126);
		c.cmp = text_byte == 8'h3d || text_byte == 8'h21 || text_byte == 8'h3c ||
			text_byte == 8'h3e;
		c.oct = text_byte >= 8'h30 && text_byte <= 8'h37;
		c.hex_ok = 1'b1;
		c.hexv = 4'd0;
		if (c.digit) c.hexv = 4'(text_byte - 8'h30);
		else if (text_byte >= 8'h61 && text_byte <= 8'h66) c.hexv = 4'(text_byte - 8'h57);
		else if (text_byte >= 8'h41 && text_byte <= 8'h46) c.hexv = 4'(text_byte - 8'h37);
		else c.hex_ok = 1'b0;
	end

	assign in_ready = cnt_q != (AW+1)'(QDEPTH);
	assign q_valid = cnt_q != '0;
	assign q_data = mem_q[rp_q];
	assign wr = in_valid && in_ready;
	assign rd = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= (wp_q == AW'(QDEPTH-1)) ? '0 : wp_q + 1'b1;
			if (rd) rp_q <= (rp_q == AW'(QDEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end

	a_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (AW+1)'(QDEPTH)) else $error("queue overflow");
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == (AW+1)'(QDEPTH) |-> !in_ready) else $error("ready while full");
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		wr && !rd |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count slip");
endmodule

/* sv/csl_back.sv */
`timescale 1ns / 1ps
module csl_back import csl_pkg::*; #(
	parameter int PB = POSITION_BITS_DEF,
	parameter int NB = NUMBER_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	output logic        q_ready,
	input  cls_t        q_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  token_kind,
	output logic [15:0] start_offset,
	output logic [15:0] token_length,
	output logic [63:0] number_value,
	output logic [7:0]  byte_value,
	output logic [7:0]  second_byte,
	output logic [3:0]  keyword_index,
	output logic [1:0]  error_code,
	output logic        last_of_run
);
	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] st;
		logic [15:0] len;
		logic [63:0] num;
		logic [7:0]  b1;
		logic [7:0]  b2;
		logic [3:0]  kw;
		logic [1:0]  err;
	} rec_t;

	localparam logic [NB-1:0] NUM_MAX = '1;

	mode_t mode_q, mode_n;
	logic [PB-1:0] pos_q, tstart_q, estart_q, pos_n, tstart_n, estart_n;
	logic [63:0] prefix_q, prefix_n;
	logic [NB-1:0] acc_q, acc_n;
	logic [15:0] dcnt_q, dcnt_n;
	logic [7:0] esc_q, esc_n, pend_q, pend_n;
	logic [1:0] oct_q, oct_n;

	// Saturation check, combinational product path: acc*10 fits within NB+4 bits.
	logic [NB+3:0] acc_x10;
	logic [NB+3:0] acc_next_w;

	// Output buffer: up to two records per item.
	rec_t r0, o0_q, o1_q;
	logic n_recs_1, n_recs_2;
	logic [1:0] cnt_q;
	logic sel_q;
	cls_t d;
	logic go;

	// Combinational record formation
	rec_t rc [2];
	logic [1:0] nr;

	function automatic rec_t mk(input kind_t k, input logic [PB-1:0] st,
		input logic [PB-1:0] ln, input logic [63:0] nm, input logic [7:0] b1,
		input logic [7:0] b2, input logic [3:0] kw, input err_t e);
		rec_t r;
		r.kind = k;
		r.st = 16'(st);
		r.len = 16'(ln);
		r.num = nm;
		r.b1 = b1;
		r.b2 = b2;
		r.kw = kw;
		r.err = e;
		return r;
	endfunction

	assign d = q_data;
	// Next item may step in while the last buffered record is being taken.
	assign q_ready = (cnt_q == 2'd0) || (n_recs_1 && out_ready);
	assign go = q_valid && q_ready;
	assign acc_x10 = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1);
	assign acc_next_w = acc_x10 + (NB+4)'(d.hexv);

	always_comb begin
		logic [PB-1:0] len;
		logic [4:0] kwm;
		logic [PB-1:0] cnt;
		logic idle_go;
		logic str_go;
		logic [7:0] sb;
		len = pos_q - tstart_q;
		kwm = kw_match(len[3:0], prefix_q);
		if (len > PB'(8)) kwm = 5'd0;
		cnt = pos_q - tstart_q;
		mode_n = mode_q;
		pos_n = pos_q + 1'b1;
		tstart_n = tstart_q;
		estart_n = estart_q;
		prefix_n = prefix_q;
		acc_n = acc_q;
		dcnt_n = dcnt_q;
		esc_n = esc_q;
		pend_n = pend_q;
		oct_n = oct_q;
		rc[0] = '0;
		rc[1] = '0;
		nr = 2'd0;
		idle_go = 1'b0;
		str_go = 1'b0;
		sb = d.b;
		if (d.eot) begin
			unique case (mode_q) inside
				M_IDENT: begin
					rc[0] = mk(kwm[4] ? K_KEYWORD : K_IDENT, tstart_q, len, '0, '0,
						'0, kwm[3:0], E_INVALID);
					nr = 2'd1;
				end
				M_NUMBER: begin
					rc[0] = mk(K_NUMBER, tstart_q, len, 64'(acc_q), '0, '0, '0, E_INVALID);
					nr = 2'd1;
				end
				M_PUNCT: begin
					rc[0] = mk(K_PUNCT, tstart_q, PB'(1), '0, pend_q, '0, '0, E_INVALID);
					nr = 2'd1;
				end
				M_STRING, M_ESC, M_OCTAL, M_HEX_FIRST, M_HEX: begin
					rc[0] = mk(K_ERROR, tstart_q, '0, '0, '0, '0, '0, E_UNCLOSED);
					nr = 2'd1;
				end
				default: nr = 2'd0;
			endcase
			rc[nr[0]] = mk(K_EOF, pos_q, '0, '0, '0, '0, '0, E_INVALID);
			nr = nr + 2'd1;
			mode_n = M_IDLE;
			pos_n = '0;
			tstart_n = '0;
			estart_n = '0;
			prefix_n = '0;
			acc_n = '0;
			dcnt_n = '0;
			esc_n = '0;
			pend_n = '0;
			oct_n = '0;
		end else begin
			unique case (mode_q)
				M_IDLE: idle_go = 1'b1;
				M_IDENT: begin
					if (d.lead || d.digit) begin
						if (cnt < PB'(8)) prefix_n = prefix_q | (64'(d.b) << {cnt[2:0], 3'b000});
					end else begin
						rc[0] = mk(kwm[4] ? K_KEYWORD : K_IDENT, tstart_q, len, '0, '0,
							'0, kwm[3:0], E_INVALID);
						nr = 2'd1;
						idle_go = 1'b1;
					end
				end
				M_NUMBER: begin
					if (d.digit) begin
						if (acc_next_w > (NB+4)'(NUM_MAX)) acc_n = NUM_MAX;
						else acc_n = acc_next_w[NB-1:0];
					end else begin
						rc[0] = mk(K_NUMBER, tstart_q, len, 64'(acc_q), '0, '0, '0, E_INVALID);
						nr = 2'd1;
						idle_go = 1'b1;
					end
				end
				M_PUNCT: begin
					if (d.b == 8'h3d) begin
						rc[0] = mk(K_PUNCT, tstart_q, PB'(2), '0, pend_q, 8'h3d, '0,
							E_INVALID);
						nr = 2'd1;
						mode_n = M_IDLE;
					end else begin
						rc[0] = mk(K_PUNCT, tstart_q, PB'(1), '0, pend_q, '0, '0, E_INVALID);
						nr = 2'd1;
						idle_go = 1'b1;
					end
				end
				M_STRING: str_go = 1'b1;
				M_ESC: begin
					if (d.oct) begin
						esc_n = d.b - 8'h30;
						oct_n = 2'd1;
						mode_n = M_OCTAL;
					end else if (d.b == 8'h78) begin
						esc_n = '0;
						mode_n = M_HEX_FIRST;
					end else if (d.b == 8'h00) begin
						rc[0] = mk(K_ERROR, tstart_q, '0, '0, '0, '0, '0, E_UNCLOSED);
						nr = 2'd1;
						mode_n = M_ERROR;
					end else begin
						rc[0] = mk(K_SBYTE, estart_q, pos_q + 1'b1 - estart_q, '0,
							letter_escape(d.b), '0, '0, E_INVALID);
						nr = 2'd1;
						dcnt_n = dcnt_q + 1'b1;
						mode_n = M_STRING;
					end
				end
				M_OCTAL: begin
					if (d.oct) begin
						sb = {esc_q[4:0], d.b[2:0]};
						esc_n = sb;
						oct_n = oct_q + 1'b1;
						if (oct_q == 2'd2) begin
							rc[0] = mk(K_SBYTE, estart_q, pos_q + 1'b1 - estart_q, '0, sb,
								'0, '0, E_INVALID);
							nr = 2'd1;
							dcnt_n = dcnt_q + 1'b1;
							mode_n = M_STRING;
						end
					end else begin
						rc[0] = mk(K_SBYTE, estart_q, pos_q - estart_q, '0, esc_q, '0,
							'0, E_INVALID);
						nr = 2'd1;
						dcnt_n = dcnt_q + 1'b1;
						mode_n = M_STRING;
						str_go = 1'b1;
					end
				end
				M_HEX_FIRST: begin
					if (d.hex_ok) begin
						esc_n = 8'(d.hexv);
						mode_n = M_HEX;
					end else if (d.b == 8'h0a || d.b == 8'h00) begin
						rc[0] = mk(K_ERROR, tstart_q, '0, '0, '0, '0, '0, E_UNCLOSED);
						nr = 2'd1;
						mode_n = M_ERROR;
					end else begin
						rc[0] = mk(K_ERROR, pos_q, '0, '0, '0, '0, '0, E_BADHEX);
						nr = 2'd1;
						mode_n = M_ERROR;
					end
				end
				M_HEX: begin
					if (d.hex_ok) begin
						esc_n = {esc_q[3:0], d.hexv};
					end else begin
						rc[0] = mk(K_SBYTE, estart_q, pos_q - estart_q, '0, esc_q, '0,
							'0, E_INVALID);
						nr = 2'd1;
						dcnt_n = dcnt_q + 1'b1;
						mode_n = M_STRING;
						str_go = 1'b1;
					end
				end
				M_ERROR: mode_n = M_ERROR;
				default: mode_n = M_ERROR;
			endcase
			if (idle_go) begin
				mode_n = M_IDLE;
				if (d.space) begin
					mode_n = M_IDLE;
				end else if (d.digit) begin
					mode_n = M_NUMBER;
					tstart_n = pos_q;
					acc_n = NB'(d.hexv);
				end else if (d.b == 8'h22) begin
					mode_n = M_STRING;
					tstart_n = pos_q;
					dcnt_n = '0;
				end else if (d.lead) begin
					mode_n = M_IDENT;
					tstart_n = pos_q;
					prefix_n = 64'(d.b);
				end else if (d.cmp) begin
					mode_n = M_PUNCT;
					tstart_n = pos_q;
					pend_n = d.b;
				end else if (d.punct) begin
					rc[nr[0]] = mk(K_PUNCT, pos_q, PB'(1), '0, d.b, '0, '0, E_INVALID);
					nr = nr + 2'd1;
				end else begin
					rc[nr[0]] = mk(K_ERROR, pos_q, '0, '0, '0, '0, '0, E_INVALID);
					nr = nr + 2'd1;
					mode_n = M_ERROR;
				end
			end
			if (str_go) begin
				if (d.b == 8'h22) begin
					rc[nr[0]] = mk(K_SEND, tstart_q, pos_q + 1'b1 - tstart_q,
						64'(dcnt_n), '0, '0, '0, E_INVALID);
					nr = nr + 2'd1;
					mode_n = M_IDLE;
				end else if (d.b == 8'h5c) begin
					estart_n = pos_q;
					mode_n = M_ESC;
				end else if (d.b == 8'h0a || d.b == 8'h00) begin
					rc[nr[0]] = mk(K_ERROR, tstart_q, '0, '0, '0, '0, '0, E_UNCLOSED);
					nr = nr + 2'd1;
					mode_n = M_ERROR;
				end else begin
					estart_n = pos_q;
					rc[nr[0]] = mk(K_SBYTE, pos_q, PB'(1), '0, d.b, '0, '0, E_INVALID);
					nr = nr + 2'd1;
					dcnt_n = dcnt_n + 1'b1;
					mode_n = M_STRING;
				end
			end
		end
	end

	assign r0 = (cnt_q == 2'd0) ? '0 : (sel_q ? o1_q : o0_q);
	assign n_recs_1 = cnt_q == 2'd1;
	assign n_recs_2 = cnt_q == 2'd2;

	assign out_valid = cnt_q != 2'd0;
	assign token_kind = r0.kind;
	assign start_offset = r0.st;
	assign token_length = r0.len;
	assign number_value = r0.num;
	assign byte_value = r0.b1;
	assign second_byte = r0.b2;
	assign keyword_index = r0.kw;
	assign error_code = r0.err;
	assign last_of_run = n_recs_1;

	always_ff @(posedge clk) begin
		if (go) begin
			o0_q <= rc[0];
			o1_q <= rc[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			pos_q <= '0;
			tstart_q <= '0;
			estart_q <= '0;
			prefix_q <= '0;
			acc_q <= '0;
			dcnt_q <= '0;
			esc_q <= '0;
			pend_q <= '0;
			oct_q <= '0;
			cnt_q <= '0;
			sel_q <= 1'b0;
		end else begin
			if (go) begin
				mode_q <= mode_n;
				pos_q <= pos_n;
				tstart_q <= tstart_n;
				estart_q <= estart_n;
				prefix_q <= prefix_n;
				acc_q <= acc_n;
				dcnt_q <= dcnt_n;
				esc_q <= esc_n;
				pend_q <= pend_n;
				oct_q <= oct_n;
				cnt_q <= nr;
				sel_q <= 1'b0;
			end else if (out_valid && out_ready) begin
				cnt_q <= cnt_q - 1'b1;
				sel_q <= n_recs_2;
			end
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("record dropped");
	a_noacc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !(n_recs_1 && out_ready) |-> !q_ready) else $error("accept while busy");
	a_mode: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(mode_q)) else $error("mode not one-hot");
	a_two: assert property (@(posedge clk) disable iff (!arst_n)
		n_recs_2 && out_ready |=> n_recs_1) else $error("second record lost");
endmodule

/* sv/c_subset_lexer_unit.sv */
`timescale 1ns / 1ps
// Streaming C-subset lexer: one text byte per item, up to two token records per item.
// Records: an item passes the front queue, then the lexer step registers its records.
// Throughput: one item per cycle while out_ready holds and it yields at most one record;
// after two records the next item steps in on the cycle its last record is taken.
// Reset (arst_n low): queue empty, lexer idle at offset zero, no record pending.
module c_subset_lexer_unit import csl_pkg::*; #(
	parameter int POSITION_BITS = POSITION_BITS_DEF,
	parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  text_byte,
	input  logic        end_of_text,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  token_kind,
	output logic [15:0] start_offset,
	output logic [15:0] token_length,
	output logic [63:0] number_value,
	output logic [7:0]  byte_value,
	output logic [7:0]  second_byte,
	output logic [3:0]  keyword_index,
	output logic [1:0]  error_code,
	output logic        last_of_run
);
	// Front: classifies each byte and parks it in a two-entry queue.
	logic q_valid, q_ready;
	cls_t q_data;

	csl_front #(.QDEPTH(2)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.text_byte(text_byte), .end_of_text(end_of_text),
		.q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
	);

	// Back: lexer state machine plus a two-record output buffer.
	csl_back #(.PB(POSITION_BITS), .NB(NUMBER_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
		.out_valid(out_valid), .out_ready(out_ready),
		.token_kind(token_kind), .start_offset(start_offset),
		.token_length(token_length), .number_value(number_value),
		.byte_value(byte_value), .second_byte(second_byte),
		.keyword_index(keyword_index), .error_code(error_code),
		.last_of_run(last_of_run)
	);
endmodule
